// ===== rtl/core/sdaf_pkg.sv =====
// Package for the signed decimal ASCII formatter.
// Holds field widths, character codes and the types shared by the
// conversion unit and the top level. Depends on nothing.
`default_nettype none

package sdaf_pkg;

  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = 4;
  localparam int CHAR_W     = 8;
  localparam int MAX_DIGITS = 10;
  // A 32-bit magnitude never needs more than ten decimal digits.
  localparam int BCD_DIGITS = 10;
  localparam int ITER_W     = $clog2(VALUE_W);
  localparam int IN_DATA_W  = ((VALUE_W + COUNT_W + 7) / 8) * 8;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;

  typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] mag;
  } dab_ctl_t;

  typedef struct packed {
    logic done;
  } dab_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/sdaf_dabble.sv =====
// Binary to BCD conversion unit: one shift-and-add-3 step per cycle.
// A request converts a 32-bit magnitude into ten BCD digits.
// Depends on sdaf_pkg.
`default_nettype none

module sdaf_dabble (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sdaf_pkg::dab_ctl_t ctl,
  output sdaf_pkg::dab_sts_t     sts,
  output sdaf_pkg::bcd_t         bcd
);

  typedef enum logic {D_IDLE, D_RUN} dab_state_t;

  dab_state_t                        state;
  logic [sdaf_pkg::VALUE_W-1:0]      bin;
  logic [sdaf_pkg::VALUE_W-1:0]      bin_next;
  logic [sdaf_pkg::ITER_W-1:0]       iter;
  sdaf_pkg::bcd_t                    adj;
  sdaf_pkg::bcd_t                    bcd_next;
  logic [sdaf_pkg::BCD_DIGITS*4+sdaf_pkg::VALUE_W-1:0] shifted;

  // Every digit of five or more is corrected before the shift.
  always_comb begin
    for (int k = 0; k < sdaf_pkg::BCD_DIGITS; k++) begin
      adj[k] = (bcd[k] >= 4'd5) ? bcd[k] + 4'd3 : bcd[k];
    end
    shifted  = {adj, bin} << 1;
    bcd_next = shifted[sdaf_pkg::BCD_DIGITS*4+sdaf_pkg::VALUE_W-1:sdaf_pkg::VALUE_W];
    bin_next = shifted[sdaf_pkg::VALUE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= D_IDLE;
      sts.done <= 1'b0;
    end else begin
      case (state)
        D_IDLE: begin
          if (ctl.start) begin
            bin      <= ctl.mag;
            bcd      <= '0;
            iter     <= '0;
            sts.done <= 1'b0;
            state    <= D_RUN;
          end
        end
        D_RUN: begin
          bin  <= bin_next;
          bcd  <= bcd_next;
          iter <= iter + 1'b1;
          if (iter == sdaf_pkg::ITER_W'(sdaf_pkg::VALUE_W - 1)) begin
            sts.done <= 1'b1;
            state    <= D_IDLE;
          end
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/signed_decimal_ascii_formatter.sv =====
// Sequence: a taken request moves to the sign state, which loads the sign
// character into the output register; the digits follow once the BCD
// conversion unit, with its 32 serial steps, is done. A new request is taken
// only after the last character of the previous one has been loaded.
// Reset clears the sequencer and the output valid flag; no clearing pass.
// Top level of the signed decimal ASCII formatter. Depends on sdaf_pkg and
// sdaf_dabble.
`default_nettype none

module signed_decimal_ascii_formatter (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // Fields from bit 0: value [31:0], digit_count [35:32], zero fill [39:36].
  input  wire logic [sdaf_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // Fields from bit 0: char_code [7:0].
  output logic [sdaf_pkg::CHAR_W-1:0]          m_tdata,
  output logic                                 m_tlast
);

  typedef enum logic [1:0] {S_IDLE, S_SIGN, S_DIGITS} state_t;

  state_t                        state;
  logic                          neg;
  logic [sdaf_pkg::COUNT_W-1:0]  cnt;
  logic [sdaf_pkg::COUNT_W-1:0]  cnt_sat;
  logic [sdaf_pkg::COUNT_W-1:0]  di;
  logic [sdaf_pkg::VALUE_W-1:0]  in_value;
  logic [sdaf_pkg::COUNT_W-1:0]  in_count;
  logic                          out_free;
  logic                          out_load;
  sdaf_pkg::dab_ctl_t            dab_ctl;
  sdaf_pkg::dab_sts_t            dab_sts;
  sdaf_pkg::bcd_t                bcd;

  assign in_value = s_tdata[sdaf_pkg::VALUE_W-1:0];
  assign in_count = s_tdata[sdaf_pkg::VALUE_W+sdaf_pkg::COUNT_W-1:sdaf_pkg::VALUE_W];
  assign cnt_sat  = (in_count > sdaf_pkg::COUNT_W'(sdaf_pkg::MAX_DIGITS))
                  ? sdaf_pkg::COUNT_W'(sdaf_pkg::MAX_DIGITS) : in_count;
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = out_free &&
                    ((state == S_SIGN) || ((state == S_DIGITS) && dab_sts.done));

  // The conversion starts on the request itself, and only when digits are
  // wanted, so a sign-only request never leaves the unit busy behind it.
  // The magnitude of the most negative value wraps to 2147483648 as an
  // unsigned number.
  assign dab_ctl = '{start: s_tvalid && s_tready && (cnt_sat != '0),
                     mag:   in_value[sdaf_pkg::VALUE_W-1] ? ('0 - in_value) : in_value};

  sdaf_dabble u_dabble (
    .clk (clk),
    .rst (rst),
    .ctl (dab_ctl),
    .sts (dab_sts),
    .bcd (bcd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            neg   <= in_value[sdaf_pkg::VALUE_W-1];
            cnt   <= cnt_sat;
            state <= S_SIGN;
          end
        end
        S_SIGN: begin
          if (out_load) begin
            m_tdata  <= neg ? sdaf_pkg::CH_MINUS : sdaf_pkg::CH_PLUS;
            m_tlast  <= (cnt == '0);
            di       <= cnt - 1'b1;
            state    <= (cnt == '0) ? S_IDLE : S_DIGITS;
          end
        end
        S_DIGITS: begin
          // Digits leave most significant first, counting the index down.
          if (out_load) begin
            m_tdata  <= sdaf_pkg::CH_ZERO + {4'b0000, bcd[di]};
            m_tlast  <= (di == '0);
            di       <= di - 1'b1;
            if (di == '0) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/sdaf_checker.sv =====
// Port-level checker for the signed decimal ASCII formatter, bound to the
// top level. Depends only on the top level's ports.
`default_nettype none

module sdaf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [39:0] s_tdata,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [7:0]  m_tdata,
  input wire logic        m_tlast
);

  // A stalled character holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output character changed while stalled");

  // Only sign characters and decimal digits ever leave the block.
  a_out_char: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata == 8'd43) || (m_tdata == 8'd45) ||
                 ((m_tdata >= 8'd48) && (m_tdata <= 8'd57)))
    else $error("output character is neither a sign nor a digit");

  // A taken request keeps the block busy in the following cycle.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("block ready right after a request");

  // While a character that is not the last one is shown, its request is unfinished.
  a_no_req_midburst: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("block ready in the middle of a character burst");

endmodule

bind signed_decimal_ascii_formatter sdaf_checker u_sdaf_checker (.*);

`default_nettype wire

// ===== tb/signed_decimal_ascii_formatter_tb.sv =====
// Testbench for the signed decimal ASCII formatter: drives requests of value and
// digit count, predicts the sign and digit characters and checks them in order.
// Depends on sdaf_pkg and the signed_decimal_ascii_formatter RTL.
`default_nettype none

module signed_decimal_ascii_formatter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Predicts the characters of each accepted request and checks them in order.
  class ascii_scoreboard;
    logic [sdaf_pkg::CHAR_W-1:0] want_char[$];
    logic                        want_last[$];
    int                          mismatches;

    function void add_request(logic [sdaf_pkg::VALUE_W-1:0] value,
                              logic [sdaf_pkg::COUNT_W-1:0] count);
      logic [sdaf_pkg::VALUE_W-1:0] mag;
      longint unsigned              scale;
      logic [sdaf_pkg::CHAR_W-1:0]  digit;
      int                           n;
      int                           i;
      int                           k;
      n = (count > sdaf_pkg::MAX_DIGITS) ? sdaf_pkg::MAX_DIGITS : int'(count);
      mag = value[sdaf_pkg::VALUE_W-1] ? (32'd0 - value) : value;
      want_char.push_back(value[sdaf_pkg::VALUE_W-1] ? sdaf_pkg::CH_MINUS : sdaf_pkg::CH_PLUS);
      want_last.push_back(n == 0);
      for (i = 0; i < n; i++) begin
        scale = 1;
        for (k = 0; k < n - i - 1; k++) scale = scale * 10;
        digit = sdaf_pkg::CHAR_W'((longint'(mag) / scale) % 10);
        want_char.push_back(sdaf_pkg::CH_ZERO + digit);
        want_last.push_back(i == n - 1);
      end
    endfunction

    function void log_mismatch(string what, logic [sdaf_pkg::CHAR_W-1:0] exp_c, logic exp_l,
                               logic [sdaf_pkg::CHAR_W-1:0] got_c, logic got_l);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected char %0d last %0b, got char %0d last %0b",
                 $realtime, what, exp_c, exp_l, got_c, got_l);
    endfunction

    function void check_char(logic [sdaf_pkg::CHAR_W-1:0] got_char, logic got_last);
      logic [sdaf_pkg::CHAR_W-1:0] exp_c;
      logic                        exp_l;
      if (want_char.size() == 0) begin
        log_mismatch("character with no request pending", 'x, 1'bx, got_char, got_last);
        return;
      end
      exp_c = want_char.pop_front();
      exp_l = want_last.pop_front();
      if (got_char !== exp_c || got_last !== exp_l)
        log_mismatch("character mismatch", exp_c, exp_l, got_char, got_last);
    endfunction

    function int pending();
      return want_char.size();
    endfunction
  endclass

  localparam int HOLD_CYCLES = 300;

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  // Fields from bit 0: value [31:0], digit_count [35:32], zero fill [39:36].
  logic [sdaf_pkg::IN_DATA_W-1:0] s_tdata;
  logic                           m_tvalid;
  logic                           m_tready;
  // Fields from bit 0: char_code [7:0].
  logic [sdaf_pkg::CHAR_W-1:0]    m_tdata;
  logic                           m_tlast;

  ascii_scoreboard sb;
  bit              no_gaps;
  bit              hold_go;
  bit              rx_hold;
  int              rx_stall_left;

  signed_decimal_ascii_formatter u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3ms;
    $display("Some tests failed");
    $finish;
  end

  // Receiver: random stalls, mostly short, with the occasional long one.
  always @(negedge clk) begin
    if (rx_hold) begin
      m_tready = 1'b0;
    end else if (no_gaps) begin
      m_tready = 1'b1;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      m_tready = 1'b0;
    end else if ($urandom_range(0, 3) != 0) begin
      m_tready = 1'b1;
    end else begin
      rx_stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      m_tready = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_char(m_tdata, m_tlast);
  end

  // Long receiver hold-off, counted here so the sender keeps offering requests.
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  task automatic send_request(logic [sdaf_pkg::VALUE_W-1:0] value,
                              logic [sdaf_pkg::COUNT_W-1:0] count);
    int gap;
    if (no_gaps) gap = 0;
    else if ($urandom_range(0, 9) < 5) gap = 0;
    else if ($urandom_range(0, 9) < 9) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata = '0;
    s_tdata[sdaf_pkg::VALUE_W-1:0] = value;
    s_tdata[sdaf_pkg::VALUE_W +: sdaf_pkg::COUNT_W] = count;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    sb.add_request(value, count);
    @(negedge clk);
  endtask

  task automatic send_random(int num);
    logic [sdaf_pkg::VALUE_W-1:0] value;
    logic [sdaf_pkg::COUNT_W-1:0] count;
    for (int i = 0; i < num; i++) begin
      case ($urandom_range(0, 4))
        0: value = $urandom();
        1: value = 32'($signed($urandom_range(0, 2000)) - 1000);
        2: case ($urandom_range(0, 3))
             0: value = 32'h8000_0000;
             1: value = 32'h7fff_ffff;
             2: value = 32'h0000_0000;
             default: value = 32'hffff_ffff;
           endcase
        3: value = $urandom() >> $urandom_range(0, 31);
        default: value = 32'd0 - ($urandom() >> $urandom_range(0, 31));
      endcase
      count = ($urandom_range(0, 9) == 0)
            ? sdaf_pkg::COUNT_W'($urandom_range(11, 15))
            : sdaf_pkg::COUNT_W'($urandom_range(0, sdaf_pkg::MAX_DIGITS));
      send_request(value, count);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    no_gaps = 1'b0;
    hold_go = 1'b0;
    rx_hold = 1'b0;
    rx_stall_left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero count, full count, saturated counts, extremes of the value.
    send_request(32'd0, 4'd0);
    send_request(32'd0, 4'd10);
    send_request(32'd1, 4'd1);
    send_request(32'hffff_ffff, 4'd1);
    send_request(32'hffff_ffff, 4'd10);
    send_request(32'h7fff_ffff, 4'd10);
    send_request(32'h8000_0000, 4'd10);
    send_request(32'h8000_0000, 4'd0);
    send_request(32'h7fff_ffff, 4'd0);
    send_request(32'd123456789, 4'd5);
    send_request(32'd0 - 32'd987654321, 4'd9);
    send_request(32'd1000000000, 4'd10);
    send_request(32'd0 - 32'd1000000000, 4'd3);
    send_request(32'd42, 4'd15);
    send_request(32'd0 - 32'd42, 4'd11);
    send_request(32'd255, 4'd12);
    send_request(32'd0, 4'd8);
    send_request(32'd9, 4'd1);
    send_request(32'd0 - 32'd10, 4'd2);
    send_request(32'd1234567890, 4'd10);
    send_request(32'd0 - 32'd1234567890, 4'd13);
    send_request(32'h8000_0000, 4'd14);

    send_random(70);

    // The receiver holds off while requests keep coming, so the input stalls.
    hold_go = 1'b1;
    send_random(12);

    // Sender pauses until every pending character has come out.
    s_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);

    no_gaps = 1'b1;
    send_random(35);
    no_gaps = 1'b0;
    send_random(100);
    s_tvalid = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/sdaf_pkg.sv
rtl/core/sdaf_dabble.sv
rtl/core/signed_decimal_ascii_formatter.sv
rtl/core/sdaf_checker.sv
tb/signed_decimal_ascii_formatter_tb.sv
